// ----- design/assert_macros.svh -----
// Assertion macros shared by the tracker RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define EHFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define EHFT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- design/ehft_pkg.sv -----
// Shared types, sizes and helpers for the key handshake flow tracker.
// No dependencies.
package ehft_pkg;

  localparam int FLOW_ENTRIES = 64;
  localparam int HANDLE_BITS  = 16;
  localparam int ADDR_W       = 48;
  localparam int HANDLE_W     = 16;
  localparam int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [HANDLE_BITS-1:0]  hdl_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [FLOW_ENTRIES-1:0] ent_vec_t;

  typedef enum logic [2:0] {
    MSG_NONE = 3'd0,
    MSG_1    = 3'd1,
    MSG_2    = 3'd2,
    MSG_3    = 3'd3,
    MSG_4    = 3'd4
  } msg_class_t;

  typedef struct packed {
    logic                has_key_frame;
    logic [ADDR_W-1:0]   source_addr;
    logic [ADDR_W-1:0]   dest_addr;
    logic                key_type_bit;
    logic                ack_bit;
    logic                mic_bit;
    logic                install_bit;
    logic                secure_bit;
    logic [HANDLE_W-1:0] frame_handle;
  } in_item_t;

  typedef struct packed {
    logic                completed;
    logic [ADDR_W-1:0]   flow_low_addr;
    logic [ADDR_W-1:0]   flow_high_addr;
    logic [HANDLE_W-1:0] handle_first;
    logic [HANDLE_W-1:0] handle_second;
    logic [HANDLE_W-1:0] handle_third;
    logic [HANDLE_W-1:0] handle_fourth;
    logic                table_full_drop;
  } out_item_t;

  // Lookup/update request into the flow table; go commits the word.
  typedef struct packed {
    logic       go;
    msg_class_t cls;
    addr_t      lo;
    addr_t      hi;
    hdl_t       handle;
  } tbl_req_t;

  // Registered outcome, updated on go.
  typedef struct packed {
    logic completed;
    logic drop;
    hdl_t h_first;
    hdl_t h_second;
    hdl_t h_third;
  } tbl_resp_t;

  function automatic idx_t oh_to_idx(input ent_vec_t v);
    idx_t idx;
    idx = '0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      if (v[i]) idx = idx | IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic msg_class_t classify(input in_item_t d);
    msg_class_t c;
    c = MSG_NONE;
    if (d.has_key_frame && d.key_type_bit) begin
      if (d.ack_bit && !d.mic_bit && !d.install_bit) c = MSG_1;
      else if (!d.ack_bit && d.mic_bit && !d.install_bit) c = d.secure_bit ? MSG_4 : MSG_2;
      else if (d.ack_bit && d.mic_bit && d.install_bit) c = MSG_3;
    end
    return c;
  endfunction

endpackage

// ----- design/ehft_in_if.sv -----
// Input channel: valid/ready plus one key frame word.
// Depends on ehft_pkg.
interface ehft_in_if;
  import ehft_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/ehft_out_if.sv -----
// Result channel: valid/ready plus one result word.
// Depends on ehft_pkg.
interface ehft_out_if;
  import ehft_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/ehft_flow_table.sv -----
// Flow table: parallel address compare over all entries, per-entry stage,
// and three handle memories (slots of messages 1 to 3). Depends on ehft_pkg.
module ehft_flow_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ehft_pkg::tbl_req_t   req,
  output ehft_pkg::tbl_resp_t  resp
);
  import ehft_pkg::*;

  ent_vec_t   valid_r;
  addr_t      lo_r    [FLOW_ENTRIES];
  addr_t      hi_r    [FLOW_ENTRIES];
  logic [1:0] stage_r [FLOW_ENTRIES];

  hdl_t slot0_mem [FLOW_ENTRIES];
  hdl_t slot1_mem [FLOW_ENTRIES];
  hdl_t slot2_mem [FLOW_ENTRIES];

  ent_vec_t   hit;
  ent_vec_t   free_vec;
  ent_vec_t   free_oh;
  logic       hit_any;
  logic       free_any;
  idx_t       hit_idx;
  idx_t       free_idx;
  logic [1:0] hit_stage;
  logic       wr_msg1;
  logic       wr_slot1;
  logic       wr_slot2;
  logic       complete;
  logic       drop;

  always_comb begin
    hit       = '0;
    hit_stage = 2'd0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      hit[i] = valid_r[i] && (lo_r[i] == req.lo) && (hi_r[i] == req.hi);
      // entries are unique, so at most one hit: and-or select
      hit_stage = hit_stage | (hit[i] ? stage_r[i] : 2'd0);
    end
  end

  assign hit_any  = |hit;
  assign hit_idx  = oh_to_idx(hit);
  assign free_vec = ~valid_r;
  assign free_oh  = free_vec & (~free_vec + ent_vec_t'(1));  // lowest free entry
  assign free_any = |free_vec;
  assign free_idx = oh_to_idx(free_oh);

  assign wr_msg1  = req.go && (req.cls == MSG_1) && (hit_any || free_any);
  assign wr_slot1 = req.go && (req.cls == MSG_2) && hit_any && (hit_stage == 2'd1);
  assign wr_slot2 = req.go && (req.cls == MSG_3) && hit_any && (hit_stage == 2'd2);
  assign complete = (req.cls == MSG_4) && hit_any && (hit_stage == 2'd3);
  assign drop     = (req.cls == MSG_1) && !hit_any && !free_any;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.go) begin
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
        if (wr_msg1 && (hit_any ? hit[i] : free_oh[i])) begin
          valid_r[i] <= 1'b1;
        end else if (hit[i] && complete) begin
          valid_r[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
        if (wr_msg1 && (hit_any ? hit[i] : free_oh[i])) begin
          lo_r[i]    <= req.lo;
          hi_r[i]    <= req.hi;
          stage_r[i] <= 2'd1;
        end else if (hit[i]) begin
          case (req.cls)
            MSG_2: begin
              if (stage_r[i] == 2'd1) stage_r[i] <= 2'd2;
              else if (stage_r[i] != 2'd2) stage_r[i] <= 2'd0;
            end
            MSG_3: begin
              if (stage_r[i] == 2'd2) stage_r[i] <= 2'd3;
              else if (stage_r[i] != 2'd3) stage_r[i] <= 2'd0;
            end
            // message 4 either completes or is out of order: both clear
            MSG_4:   stage_r[i] <= 2'd0;
            default: stage_r[i] <= stage_r[i];
          endcase
        end
      end
    end
  end

  // handle slots: one write and one registered read per memory
  always_ff @(posedge clk) begin
    if (wr_msg1) slot0_mem[hit_any ? hit_idx : free_idx] <= req.handle;
    if (wr_slot1) slot1_mem[hit_idx] <= req.handle;
    if (wr_slot2) slot2_mem[hit_idx] <= req.handle;
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      resp.h_first   <= slot0_mem[hit_idx];
      resp.h_second  <= slot1_mem[hit_idx];
      resp.h_third   <= slot2_mem[hit_idx];
      resp.completed <= complete;
      resp.drop      <= drop;
    end
  end

endmodule

// ----- design/eapol_handshake_flow_tracker.sv -----
// Key handshake flow tracker, top level.
// A word is registered in an input stage, then its table result in an output stage.
// One word per cycle unless output stalls; the table compares all entries at once.
// Reset (rst_n, synchronous): clears both channel stages and every entry's
// valid bit; addresses, stages and handle memories are not cleared.
// Depends on ehft_pkg, ehft_in_if, ehft_out_if, ehft_flow_table, assert_macros.svh.
`include "assert_macros.svh"

module eapol_handshake_flow_tracker (
  input logic        clk,
  input logic        rst_n,
  ehft_in_if.sink    in_ch,
  ehft_out_if.source out_ch
);
  import ehft_pkg::*;

  logic      in_vld_r;
  in_item_t  in_data_r;
  logic      out_vld_r;
  addr_t     lo_r;
  addr_t     hi_r;
  hdl_t      h4_r;
  logic      adv;
  addr_t     src;
  addr_t     dst;
  tbl_req_t  req;
  tbl_resp_t resp;

  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_data_r <= in_ch.data;
  end

  assign src = in_data_r.source_addr;
  assign dst = in_data_r.dest_addr;

  always_comb begin
    req.go     = adv;
    req.cls    = classify(in_data_r);
    req.lo     = (src < dst) ? src : dst;
    req.hi     = (src < dst) ? dst : src;
    req.handle = in_data_r.frame_handle[HANDLE_BITS-1:0];
  end

  ehft_flow_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .resp  (resp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r <= req.lo;
      hi_r <= req.hi;
      h4_r <= req.handle;
    end
  end

  always_comb begin
    out_ch.valid                = out_vld_r;
    out_ch.data.completed       = resp.completed;
    out_ch.data.flow_low_addr   = resp.completed ? lo_r : '0;
    out_ch.data.flow_high_addr  = resp.completed ? hi_r : '0;
    out_ch.data.handle_first    = resp.completed ? HANDLE_W'(resp.h_first) : '0;
    out_ch.data.handle_second   = resp.completed ? HANDLE_W'(resp.h_second) : '0;
    out_ch.data.handle_third    = resp.completed ? HANDLE_W'(resp.h_third) : '0;
    out_ch.data.handle_fourth   = resp.completed ? HANDLE_W'(h4_r) : '0;
    out_ch.data.table_full_drop = resp.drop;
  end

  `EHFT_NEVER(a_comp_drop_excl, out_vld_r && resp.completed && resp.drop, "completion and drop together")
  `EHFT_ASSERT(a_adv_fills_out, adv |=> out_vld_r, "advanced word did not reach output")
  `EHFT_ASSERT(a_in_hold, (in_vld_r && !adv) |=> (in_vld_r && $stable(in_data_r)), "held word lost")

endmodule
